[rtl/ndt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types, codes and constants of the neighbour discovery table.
// ----------------------------------------------------------------------------
package ndt_pkg;

    localparam int MAX_NEIGHBOURS_DEFAULT = 32;
    localparam int QUEUE_DEPTH            = 2;
    localparam int QUEUE_PTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd80;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [7:0] TYPE_HELLO     = 8'd1;
    localparam logic [7:0] TYPE_HELLO_ACK = 8'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_KNOWN   = 3'd1;
    localparam logic [2:0] ST_WEAK    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;
    localparam logic [2:0] ST_HIT     = 3'd6;
    localparam logic [2:0] ST_MISS    = 3'd7;

    // operations handed from the front end to the table engine
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_REPORT = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [15:0]       sender_address;
        logic [7:0]        message_type;
        logic signed [7:0] signal_strength;
        logic [4:0]        peer_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        ack_request;
        logic [15:0] ack_address;
        logic [15:0] lookup_address;
        logic [5:0]  neighbour_count;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  status;
        logic        ack;
        logic [15:0] address;
        logic [4:0]  index;
    } job_t;

endpackage
`default_nettype wire

[rtl/ndt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndt_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/ndt_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_front
// Accepts commands, holds the RSSI threshold and classifies each command
// into a job for the table engine.
// ----------------------------------------------------------------------------
module ndt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ndt_pkg::in_item_t item,
    output logic                  busy,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             queue_full,
    output logic                  push,
    output ndt_pkg::job_t         job
);
    import ndt_pkg::*;

    logic signed [7:0] threshold_reg;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RSSI_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= $signed(cfg_data);
        end
    end

    always_comb
    begin
        job.op      = OP_REPORT;
        job.status  = ST_IGNORED;
        job.ack     = 1'b0;
        job.address = item.sender_address;
        job.index   = item.peer_index;
        unique case (item.cmd)
            CMD_FRAME:
            begin
                if (item.sender_address != 16'd0)
                begin
                    if (item.message_type == TYPE_HELLO)
                    begin
                        if ($signed(item.signal_strength) > threshold_reg)
                        begin
                            job.op  = OP_INSERT;
                            job.ack = 1'b1;
                        end
                        else
                        begin
                            job.status = ST_WEAK;
                        end
                    end
                    else if (item.message_type == TYPE_HELLO_ACK)
                    begin
                        job.op = OP_INSERT;
                    end
                end
            end
            CMD_CLEAR:  job.op = OP_CLEAR;
            CMD_LOOKUP: job.op = OP_LOOKUP;
            default:    job.op = OP_REPORT;
        endcase
    end

endmodule
`default_nettype wire

[rtl/ndt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_queue
// Short job queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module ndt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ndt_pkg::job_t push_job,
    input  wire logic          pop,
    output ndt_pkg::job_t      head,
    output logic               empty,
    output logic               full
);
    import ndt_pkg::*;

    job_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign empty = (count_reg == QUEUE_CNT_W'(0));
    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/ndt_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_back
// Table engine: walks the stored entries one per cycle, appends new senders,
// serves lookups and clears, and drives the result strobe.
// ----------------------------------------------------------------------------
module ndt_back #(
    parameter int MAX_NEIGHBOURS = ndt_pkg::MAX_NEIGHBOURS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          queue_empty,
    input  wire ndt_pkg::job_t queue_head,
    output logic               pop,
    output logic               done,
    output ndt_pkg::out_item_t result
);
    import ndt_pkg::*;

    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
    localparam int AW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int IW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;

    logic [1:0]    state_reg, state_next;
    job_t          job_reg, job_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          cmp_last_reg, cmp_last_next;
    logic          done_reg, done_next;
    out_item_t     result_reg, result_next;

    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [15:0]   ram_rd_data;
    logic          issue;
    logic          lookup_hit;
    logic          table_full;
    logic [IW-1:0] head_idx_w;

    ndt_ram #(
        .WIDTH  (16),
        .DEPTH  (MAX_NEIGHBOURS),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (job_next.address),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pop        = (state_reg == S_IDLE) && !queue_empty;
    assign issue      = (rd_idx_reg < count_reg);
    assign table_full = (count_reg == CW'(MAX_NEIGHBOURS));
    assign head_idx_w = IW'(queue_head.index);
    assign lookup_hit = (head_idx_w < IW'(count_reg));
    assign done       = done_reg;
    assign result     = result_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        done_next      = 1'b0;
        result_next    = '0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = rd_idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    job_next = queue_head;
                    case (queue_head.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(0))
                            begin
                                ram_wr_en          = 1'b1;
                                count_next         = count_reg + 1'b1;
                                done_next          = 1'b1;
                                result_next.status = ST_ADDED;
                                if (queue_head.ack)
                                begin
                                    result_next.ack_request = 1'b1;
                                    result_next.ack_address = queue_head.address;
                                end
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next         = '0;
                            done_next          = 1'b1;
                            result_next.status = ST_CLEARED;
                        end
                        OP_LOOKUP:
                        begin
                            if (lookup_hit)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(head_idx_w);
                                state_next  = S_LOOK;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_MISS;
                            end
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next.status = queue_head.status;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // reads run one entry ahead of the compare
                if (issue)
                begin
                    ram_rd_en      = 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = (rd_idx_reg == count_reg - 1'b1);
                end
                if (cmp_valid_reg)
                begin
                    if (ram_rd_data == job_reg.address)
                    begin
                        done_next          = 1'b1;
                        result_next.status = ST_KNOWN;
                        cmp_valid_next     = 1'b0;
                        state_next         = S_IDLE;
                    end
                    else if (cmp_last_reg)
                    begin
                        done_next      = 1'b1;
                        cmp_valid_next = 1'b0;
                        state_next     = S_IDLE;
                        if (table_full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_wr_en          = 1'b1;
                            count_next         = count_reg + 1'b1;
                            result_next.status = ST_ADDED;
                            if (job_reg.ack)
                            begin
                                result_next.ack_request = 1'b1;
                                result_next.ack_address = job_reg.address;
                            end
                        end
                    end
                end
            end
            S_LOOK:
            begin
                done_next                  = 1'b1;
                result_next.status         = ST_HIT;
                result_next.lookup_address = ram_rd_data;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.neighbour_count = 6'(count_next);
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            done_reg      <= done_next;
        end
    end

endmodule
`default_nettype wire

[rtl/neighbour_discovery_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// neighbour_discovery_table
// Table of neighbour addresses filled from received HELLO / HELLO_ACK frames.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry job queue
// sits behind the command port, so busy rises only when two commands are
// waiting. Every command gives exactly one result, shown on result for a single
// cycle with done high; it cannot be held off, so sample it when done is seen.
// Commands are served in order. A frame that must be looked up in the table
// walks the stored entries one per cycle through the table RAM's read port,
// stopping early on a match. The RSSI threshold is written through the
// cfg channel, which is always ready; write it only while no command is open.
// ----------------------------------------------------------------------------
module neighbour_discovery_table #(
    parameter int MAX_NEIGHBOURS = ndt_pkg::MAX_NEIGHBOURS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ndt_pkg::in_item_t item,
    output logic                   busy,
    output logic                   done,
    output ndt_pkg::out_item_t     result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);
    import ndt_pkg::*;

    job_t push_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_empty;
    logic queue_full;

    ndt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    ndt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    ndt_back #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_head  (head_job),
        .pop         (pop),
        .done        (done),
        .result      (result)
    );

endmodule
`default_nettype wire

[rtl/ndt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ndt_checker
// Port-level checks on the neighbour discovery table results.
// ----------------------------------------------------------------------------
module ndt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               done,
    input wire ndt_pkg::out_item_t result
);
    import ndt_pkg::*;

    a_ack_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.ack_request |-> result.status == ST_ADDED &&
                                       result.ack_address != 16'd0)
        else $error("ack requested on a result that did not add a sender");

    a_ack_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ack_request |-> result.ack_address == 16'd0)
        else $error("ack address set without an ack request");

    a_lookup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_HIT |-> result.lookup_address == 16'd0)
        else $error("lookup address set on a non-hit result");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_HIT |-> result.lookup_address != 16'd0)
        else $error("lookup hit returned an empty entry");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_CLEARED |-> result.neighbour_count == 6'd0)
        else $error("table not empty after clear");

endmodule

bind neighbour_discovery_table ndt_checker u_ndt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);
`default_nettype wire

[tb/sv/ndt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndt_scoreboard
// Watches the command, result and threshold channels of the neighbour table,
// keeps its own copy of the table and threshold, forecasts the result of each
// accepted command and checks every result against the oldest forecast.
// ----------------------------------------------------------------------------
module ndt_scoreboard
    import ndt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    item,
    input  logic        done,
    input  out_item_t   result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output logic [7:0]  codes_seen
);

    logic [15:0]       peer_addr [MAX_NEIGHBOURS_DEFAULT];
    logic [5:0]        peer_total;
    logic signed [7:0] hello_floor;
    out_item_t         forecast [$];
    out_item_t         want;

    // first matching or first free slot, left to right
    function automatic logic [2:0] enrol_peer(logic [15:0] addr);
        logic [2:0] verdict;
        verdict = ST_FULL;
        for (int i = 0; i < MAX_NEIGHBOURS_DEFAULT; i++)
        begin
            if (verdict == ST_FULL)
            begin
                if (peer_addr[i] == addr)
                    verdict = ST_KNOWN;
                else if (peer_addr[i] == 16'h0000)
                begin
                    peer_addr[i] = addr;
                    peer_total   = peer_total + 6'd1;
                    verdict      = ST_ADDED;
                end
            end
        end
        return verdict;
    endfunction

    function automatic out_item_t resolve_command(in_item_t c);
        out_item_t r;
        r        = '0;
        r.status = ST_IGNORED;
        case (c.cmd)
            CMD_FRAME:
            begin
                if (c.sender_address != 16'h0000)
                begin
                    if (c.message_type == TYPE_HELLO)
                    begin
                        if ($signed(c.signal_strength) > hello_floor)
                        begin
                            r.status = enrol_peer(c.sender_address);
                            if (r.status == ST_ADDED)
                            begin
                                r.ack_request = 1'b1;
                                r.ack_address = c.sender_address;
                            end
                        end
                        else
                            r.status = ST_WEAK;
                    end
                    else if (c.message_type == TYPE_HELLO_ACK)
                        r.status = enrol_peer(c.sender_address);
                end
            end
            CMD_CLEAR:
            begin
                foreach (peer_addr[i])
                    peer_addr[i] = 16'h0000;
                peer_total = '0;
                r.status   = ST_CLEARED;
            end
            CMD_LOOKUP:
            begin
                if (c.peer_index < peer_total)
                begin
                    r.status         = ST_HIT;
                    r.lookup_address = peer_addr[c.peer_index];
                end
                else
                    r.status = ST_MISS;
            end
            default: ;
        endcase
        r.neighbour_count = peer_total;
        return r;
    endfunction

    function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (peer_addr[i])
                peer_addr[i] = 16'h0000;
            peer_total   = '0;
            hello_floor  = RSSI_THRESHOLD_RESET;
            forecast.delete();
            fail_count   = 0;
            results_seen = 0;
            codes_seen   = '0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hello_floor = cfg_data;
            if (start && !busy)
                forecast.push_back(resolve_command(item));
            if (done)
            begin
                results_seen++;
                codes_seen[result.status] = 1'b1;
                if (forecast.size() == 0)
                begin
                    $display("%0t: result with no transaction outstanding, expected none, got %p",
                             $time, result);
                    fail_count++;
                end
                else
                begin
                    want = forecast.pop_front();
                    if (!(field_ok("status", 16'(want.status), 16'(result.status))
                          & field_ok("ack_request", 16'(want.ack_request),
                                     16'(result.ack_request))
                          & field_ok("ack_address", want.ack_address, result.ack_address)
                          & field_ok("lookup_address", want.lookup_address,
                                     result.lookup_address)
                          & field_ok("neighbour_count", 16'(want.neighbour_count),
                                     16'(result.neighbour_count))))
                        fail_count++;
                end
            end
            pending <= forecast.size();
        end
    end

endmodule

[tb/sv/tb_neighbour_discovery_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neighbour_discovery_table
// Drives directed and random HELLO / HELLO_ACK / clear / lookup commands into
// the neighbour table over several RSSI thresholds and idle patterns; the
// checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_neighbour_discovery_table;
    import ndt_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 50;
    localparam int         PHASE_ITEMS    = 196;

    logic        clk;
    logic        rst_n;
    logic        start;
    in_item_t    item;
    logic        busy;
    logic        done;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int                fail_count;
    int                pending;
    int                results_seen;
    logic [7:0]        codes_seen;
    int                commands_sent;
    int                idle_pct;
    int                quiet_cycles;
    logic signed [7:0] threshold_now;

    neighbour_discovery_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ndt_scoreboard u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .done         (done),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .codes_seen   (codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // no transaction on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_item_t pack_cmd(logic [1:0] c, logic [15:0] addr, logic [7:0] mtype,
                                          logic [7:0] rssi, logic [4:0] idx);
        in_item_t r;
        r.cmd             = c;
        r.sender_address  = addr;
        r.message_type    = mtype;
        r.signal_strength = rssi;
        r.peer_index      = idx;
        return r;
    endfunction

    function automatic logic [7:0] pick_rssi();
        int lo;
        lo = int'(threshold_now) + 1;
        case ($urandom_range(0, 3))
            0: return 8'($urandom);
            1: return threshold_now;
            default: return (lo > 127) ? 8'sd127 : 8'(lo + $urandom_range(0, 127 - lo));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return TYPE_HELLO_ACK;
        else if (roll < 9)
            return TYPE_HELLO;
        return 8'($urandom);
    endfunction

    function automatic in_item_t noise_cmd();
        return pack_cmd(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    endfunction

    task automatic issue(in_item_t c);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= c;
        do @(posedge clk); while (busy !== 1'b0);
        commands_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_threshold(logic signed [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid     <= 1'b0;
        threshold_now  = v;
    endtask

    task automatic run_sequence();
        int kind;
        int n;
        int base;
        int span;
        int roll;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // clear, then walk through a block of addresses, which may fill the table
            base = $urandom_range(1, 65535 - 48);
            n    = $urandom_range(28, 44);
            issue(pack_cmd(CMD_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                           5'($urandom)));
            for (int j = 0; j < n; j++)
                issue(pack_cmd(CMD_FRAME,
                               16'(base + (($urandom_range(0, 5) == 0) ?
                                            $urandom_range(0, j) : j)),
                               pick_type(), pick_rssi(), 5'($urandom)));
            repeat ($urandom_range(2, 8))
                issue(pack_cmd(CMD_LOOKUP, 16'($urandom), 8'($urandom), 8'($urandom),
                               5'($urandom_range(0, 31))));
        end
        else if (kind < 8)
        begin
            base = $urandom_range(1, 65535 - 48);
            span = $urandom_range(2, 40);
            n    = $urandom_range(10, 40);
            repeat (n)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    issue(pack_cmd(CMD_FRAME, 16'(base + $urandom_range(0, span - 1)),
                                   pick_type(), pick_rssi(), 5'($urandom)));
                else if (roll < 85)
                    issue(pack_cmd(CMD_LOOKUP, 16'($urandom), 8'($urandom), 8'($urandom),
                                   5'($urandom)));
                else if (roll < 90)
                    issue(pack_cmd(CMD_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
                                   5'($urandom)));
                else
                    issue(noise_cmd());
            end
        end
        else
            repeat ($urandom_range(3, 10))
                issue(noise_cmd());
        if ($urandom_range(0, 7) == 0)
            settle();
    endtask

    initial
    begin
        logic signed [7:0] floors [5];
        int                idles  [5];
        int                phase_end;
        floors        = '{-8'sd128, 8'sd127, 8'sd0, -8'sd80, 8'sd1};
        idles         = '{0, 61, 6, 61, 0};
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        commands_sent = 0;
        idle_pct      = 0;
        threshold_now = RSSI_THRESHOLD_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold of -80 still in force
        issue(pack_cmd(CMD_LOOKUP,  16'h0000, 8'h00, 8'h00, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h0000, TYPE_HELLO, 8'sd127, 5'd31));
        issue(pack_cmd(CMD_FRAME,   16'h0000, TYPE_HELLO_ACK, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'hFFFF, TYPE_HELLO, -8'sd80, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'hFFFF, TYPE_HELLO, -8'sd79, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'hFFFF, TYPE_HELLO, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'hFFFF, TYPE_HELLO, -8'sd128, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h0001, TYPE_HELLO_ACK, -8'sd128, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h0001, TYPE_HELLO_ACK, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'hFFFF, TYPE_HELLO_ACK, 8'sd0, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h1234, 8'h00, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h1234, 8'hFF, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_UNUSED,  16'hFFFF, 8'hFF, 8'hFF, 5'd31));
        issue(pack_cmd(CMD_LOOKUP,  16'h0000, 8'h00, 8'h00, 5'd0));
        issue(pack_cmd(CMD_LOOKUP,  16'h0000, 8'h00, 8'h00, 5'd1));
        issue(pack_cmd(CMD_LOOKUP,  16'h0000, 8'h00, 8'h00, 5'd2));
        issue(pack_cmd(CMD_LOOKUP,  16'hFFFF, 8'hFF, 8'hFF, 5'd31));
        issue(pack_cmd(CMD_CLEAR,   16'hFFFF, 8'hFF, 8'hFF, 5'd31));
        issue(pack_cmd(CMD_LOOKUP,  16'h0000, 8'h00, 8'h00, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h8000, TYPE_HELLO, 8'sd127, 5'd0));
        issue(pack_cmd(CMD_FRAME,   16'h7FFF, TYPE_HELLO, 8'sd0, 5'd0));
        settle();

        for (int p = 0; p < 5; p++)
        begin
            set_threshold((p == 2) ? 8'($urandom) : floors[p]);
            idle_pct  = idles[p];
            phase_end = commands_sent + PHASE_ITEMS;
            while (commands_sent < phase_end)
                run_sequence();
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d commands over 5 threshold settings and 3 idle patterns,",
                 commands_sent);
        $display("%0d results checked; status codes seen (7 down to 0): %b",
                 results_seen, codes_seen);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
